>>> hw/rtl/tfn_pkg.sv
// Shared types, widths and constants for the triangle face normal pipeline.
package tfn_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_WIDTH     = OUT_FRAC_BITS + 2;

  localparam int EDGE_W   = COORD_WIDTH + 1;
  localparam int PROD_W   = 2 * EDGE_W;
  localparam int MAG_W    = PROD_W + 1;
  localparam int NORM_BITS = 31;
  localparam int BLEN_W   = $clog2(MAG_W + 1);
  localparam int SQ_W     = 2 * NORM_BITS;
  localparam int SUM_W    = SQ_W + 2;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int REM_W    = ROOT_W + 1;
  localparam int QUO_W    = OUT_FRAC_BITS + 2;
  localparam int NUM_W    = NORM_BITS + OUT_FRAC_BITS + 1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vert0_x;
    logic signed [COORD_WIDTH-1:0] vert0_y;
    logic signed [COORD_WIDTH-1:0] vert0_z;
    logic signed [COORD_WIDTH-1:0] vert1_x;
    logic signed [COORD_WIDTH-1:0] vert1_y;
    logic signed [COORD_WIDTH-1:0] vert1_z;
    logic signed [COORD_WIDTH-1:0] vert2_x;
    logic signed [COORD_WIDTH-1:0] vert2_y;
    logic signed [COORD_WIDTH-1:0] vert2_z;
  } face_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] normal_x;
    logic signed [OUT_WIDTH-1:0] normal_y;
    logic signed [OUT_WIDTH-1:0] normal_z;
    logic                        degenerate;
  } unit_t;

  // Per-item flags that ride along the pipeline
  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } side_t;

  typedef logic [MAG_W-1:0]     mag_t;
  typedef logic [NORM_BITS-1:0] norm_t;

endpackage

>>> hw/rtl/tfn_cross.sv
// Edge differences, six partial products and the cross product magnitudes.
module tfn_cross (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  face_valid,
  input  tfn_pkg::face_t        face,
  output logic                  vld,
  output tfn_pkg::mag_t         mag [3],
  output tfn_pkg::side_t        side
);
  import tfn_pkg::*;

  logic                     v1, v2;
  logic signed [EDGE_W-1:0] e1 [3];
  logic signed [EDGE_W-1:0] e2 [3];
  logic signed [PROD_W-1:0] p  [6];
  logic signed [MAG_W-1:0]  c  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      vld <= 1'b0;
    end else if (adv) begin
      v1  <= face_valid;
      v2  <= v1;
      vld <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1[0] <= EDGE_W'(face.vert0_x) - EDGE_W'(face.vert1_x);
      e1[1] <= EDGE_W'(face.vert0_y) - EDGE_W'(face.vert1_y);
      e1[2] <= EDGE_W'(face.vert0_z) - EDGE_W'(face.vert1_z);
      e2[0] <= EDGE_W'(face.vert1_x) - EDGE_W'(face.vert2_x);
      e2[1] <= EDGE_W'(face.vert1_y) - EDGE_W'(face.vert2_y);
      e2[2] <= EDGE_W'(face.vert1_z) - EDGE_W'(face.vert2_z);
      p[0] <= e1[1] * e2[2];
      p[1] <= e1[2] * e2[1];
      p[2] <= e1[2] * e2[0];
      p[3] <= e1[0] * e2[2];
      p[4] <= e1[0] * e2[1];
      p[5] <= e1[1] * e2[0];
    end
  end

  always_comb begin
    c[0] = MAG_W'(p[0]) - MAG_W'(p[1]);
    c[1] = MAG_W'(p[2]) - MAG_W'(p[3]);
    c[2] = MAG_W'(p[4]) - MAG_W'(p[5]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        mag[i]      <= c[i][MAG_W-1] ? MAG_W'(-c[i]) : MAG_W'(c[i]);
        side.neg[i] <= c[i][MAG_W-1];
      end
      side.degen <= 1'b0;
    end
  end

endmodule

>>> hw/rtl/tfn_scale.sv
// Normalize the cross product to 31 bits and form the sum of squares.
module tfn_scale (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_vld,
  input  tfn_pkg::mag_t          mag [3],
  input  tfn_pkg::side_t         in_side,
  output logic                   vld,
  output tfn_pkg::norm_t         a [3],
  output logic [tfn_pkg::SUM_W-1:0] sum,
  output tfn_pkg::side_t         side
);
  import tfn_pkg::*;

  logic              v4, v5, v6;
  mag_t              m4 [3];
  logic [BLEN_W-1:0] b4;
  side_t             s4, s5, s6;
  mag_t              orv;
  logic [BLEN_W-1:0] blen;
  norm_t             a5 [3];
  norm_t             a6 [3];
  logic [SQ_W-1:0]   sq [3];
  mag_t              shr [3];

  always_comb begin
    orv  = mag[0] | mag[1] | mag[2];
    blen = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (orv[i]) blen = BLEN_W'(i + 1);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shr[i] = m4[i] >> (b4 - BLEN_W'(NORM_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      vld <= 1'b0;
    end else if (adv) begin
      v4  <= in_vld;
      v5  <= v4;
      v6  <= v5;
      vld <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m4       <= mag;
      b4       <= blen;
      s4.neg   <= in_side.neg;
      s4.degen <= (orv == '0);
      s5       <= s4;
      s6       <= s5;
      side     <= s6;
      for (int i = 0; i < 3; i++) begin
        if (b4 > BLEN_W'(NORM_BITS)) a5[i] <= shr[i][NORM_BITS-1:0];
        else a5[i] <= m4[i][NORM_BITS-1:0] << (BLEN_W'(NORM_BITS) - b4);
        sq[i] <= a5[i] * a5[i];
      end
      a6  <= a5;
      a   <= a6;
      sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    end
  end

endmodule

>>> hw/rtl/tfn_sqrt.sv
// Integer square root, one result bit per pipeline stage.
module tfn_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_vld,
  input  tfn_pkg::norm_t             in_a [3],
  input  logic [tfn_pkg::SUM_W-1:0]  in_sum,
  input  tfn_pkg::side_t             in_side,
  output logic                       vld,
  output tfn_pkg::norm_t             a [3],
  output logic [tfn_pkg::ROOT_W-1:0] root,
  output tfn_pkg::side_t             side
);
  import tfn_pkg::*;

  logic              sv [ROOT_W+1];
  logic [SUM_W-1:0]  ss [ROOT_W+1];
  logic [REM_W-1:0]  sr [ROOT_W+1];
  logic [ROOT_W-1:0] sq [ROOT_W+1];
  norm_t             sa [ROOT_W+1][3];
  side_t             sd [ROOT_W+1];

  assign sv[0] = in_vld;
  assign ss[0] = in_sum;
  assign sr[0] = '0;
  assign sq[0] = '0;
  assign sa[0] = in_a;
  assign sd[0] = in_side;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    logic [REM_W+1:0]  cur, trial;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    always_comb begin
      cur   = {sr[g], ss[g][SUM_W-1-2*g -: 2]};
      trial = {{(REM_W-ROOT_W){1'b0}}, sq[g], 2'b01};
      if (cur >= trial) begin
        rem_next  = REM_W'(cur - trial);
        root_next = {sq[g][ROOT_W-2:0], 1'b1};
      end else begin
        rem_next  = cur[REM_W-1:0];
        root_next = {sq[g][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) sv[g+1] <= 1'b0;
      else if (adv) sv[g+1] <= sv[g];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ss[g+1] <= ss[g];
        sr[g+1] <= rem_next;
        sq[g+1] <= root_next;
        sa[g+1] <= sa[g];
        sd[g+1] <= sd[g];
      end
    end
  end

  assign vld  = sv[ROOT_W];
  assign a    = sa[ROOT_W];
  assign root = sq[ROOT_W];
  assign side = sd[ROOT_W];

endmodule

>>> hw/rtl/tfn_div.sv
// Rounded quotient a * 2^frac / length, three lanes, one quotient bit per stage.
module tfn_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_vld,
  input  tfn_pkg::norm_t             in_a [3],
  input  logic [tfn_pkg::ROOT_W-1:0] len,
  input  tfn_pkg::side_t             in_side,
  output logic                       vld,
  output logic [tfn_pkg::QUO_W-1:0]  quo [3],
  output tfn_pkg::side_t             side
);
  import tfn_pkg::*;

  logic              dv [QUO_W+1];
  logic [ROOT_W-1:0] dl [QUO_W+1];
  logic [NUM_W-1:0]  dn [QUO_W+1][3];
  logic [REM_W-1:0]  dr [QUO_W+1][3];
  logic [QUO_W-1:0]  dq [QUO_W+1][3];
  side_t             dd [QUO_W+1];

  // Numerator with half the divisor added for round to nearest
  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (adv) dv[0] <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl[0] <= len;
      dd[0] <= in_side;
      for (int i = 0; i < 3; i++) begin
        dn[0][i] <= (NUM_W'(in_a[i]) << OUT_FRAC_BITS) + NUM_W'(len >> 1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dr[0][i] = REM_W'(dn[0][i][NUM_W-1:QUO_W]);
      dq[0][i] = '0;
    end
  end

  for (genvar g = 0; g < QUO_W; g++) begin : g_stage
    logic [REM_W:0]   cur  [3];
    logic [REM_W-1:0] rnxt [3];
    logic [QUO_W-1:0] qnxt [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        cur[i] = {dr[g][i], dn[g][i][QUO_W-1-g]};
        if (cur[i] >= (REM_W+1)'(dl[g])) begin
          rnxt[i] = REM_W'(cur[i] - (REM_W+1)'(dl[g]));
          qnxt[i] = {dq[g][i][QUO_W-2:0], 1'b1};
        end else begin
          rnxt[i] = cur[i][REM_W-1:0];
          qnxt[i] = {dq[g][i][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv[g+1] <= 1'b0;
      else if (adv) dv[g+1] <= dv[g];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dl[g+1] <= dl[g];
        dn[g+1] <= dn[g];
        dr[g+1] <= rnxt;
        dq[g+1] <= qnxt;
        dd[g+1] <= dd[g];
      end
    end
  end

  assign vld  = dv[QUO_W];
  assign quo  = dq[QUO_W];
  assign side = dd[QUO_W];

endmodule

>>> hw/rtl/triangle_face_normal_top.sv
// Top level of the triangle unit normal pipeline.
//
// Accepts one triangle (three Q12.12 vertices) per clock unless the result
// side stalls, and returns its unit normal in Q1.14 with a degenerate flag
// after stages for edges and cross product, normalization and sum of squares,
// the square root (one root bit per stage), the three parallel dividers (one
// quotient bit per stage) and one output register. A stall on the
// result side freezes the whole pipeline; no transfer is lost or repeated.
module triangle_face_normal_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            face_valid,
  output logic            face_ready,
  input  tfn_pkg::face_t  face,
  output logic            unit_valid,
  input  logic            unit_ready,
  output tfn_pkg::unit_t  unit
);
  import tfn_pkg::*;

  localparam logic [QUO_W-1:0] ONE = QUO_W'(1) << OUT_FRAC_BITS;

  logic              adv;
  logic              c_vld, s_vld, r_vld, d_vld;
  mag_t              c_mag [3];
  side_t             c_side, s_side, r_side, d_side;
  norm_t             s_a [3];
  norm_t             r_a [3];
  logic [SUM_W-1:0]  s_sum;
  logic [ROOT_W-1:0] r_root;
  logic [QUO_W-1:0]  d_quo [3];
  logic [OUT_WIDTH-1:0] res [3];

  // Advance whenever the output register is empty or being drained
  assign adv        = !unit_valid || unit_ready;
  assign face_ready = adv && !rst;

  tfn_cross u_cross (
    .clk, .rst, .adv, .face_valid, .face,
    .vld(c_vld), .mag(c_mag), .side(c_side)
  );

  tfn_scale u_scale (
    .clk, .rst, .adv, .in_vld(c_vld), .mag(c_mag), .in_side(c_side),
    .vld(s_vld), .a(s_a), .sum(s_sum), .side(s_side)
  );

  tfn_sqrt u_sqrt (
    .clk, .rst, .adv, .in_vld(s_vld), .in_a(s_a), .in_sum(s_sum), .in_side(s_side),
    .vld(r_vld), .a(r_a), .root(r_root), .side(r_side)
  );

  tfn_div u_div (
    .clk, .rst, .adv, .in_vld(r_vld), .in_a(r_a), .len(r_root), .in_side(r_side),
    .vld(d_vld), .quo(d_quo), .side(d_side)
  );

  // Clamp to one, apply the sign, zero everything for a degenerate face
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [QUO_W-1:0] q;
      q = (d_quo[i] > ONE) ? ONE : d_quo[i];
      if (d_side.degen) res[i] = '0;
      else if (d_side.neg[i]) res[i] = OUT_WIDTH'(-q);
      else res[i] = OUT_WIDTH'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) unit_valid <= 1'b0;
    else if (adv) unit_valid <= d_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unit.normal_x   <= res[0];
      unit.normal_y   <= res[1];
      unit.normal_z   <= res[2];
      unit.degenerate <= d_side.degen;
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    unit_valid && unit.degenerate |->
      unit.normal_x == '0 && unit.normal_y == '0 && unit.normal_z == '0)
    else $error("degenerate result carries a nonzero normal");

  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    unit_valid && !unit.degenerate |->
      unit.normal_x != '0 || unit.normal_y != '0 || unit.normal_z != '0)
    else $error("non-degenerate result has a zero normal");

  a_range: assert property (@(posedge clk) disable iff (rst)
    unit_valid |->
      $signed(unit.normal_x) <= $signed(OUT_WIDTH'(ONE)) &&
      $signed(unit.normal_x) >= -$signed(OUT_WIDTH'(ONE)) &&
      $signed(unit.normal_y) <= $signed(OUT_WIDTH'(ONE)) &&
      $signed(unit.normal_y) >= -$signed(OUT_WIDTH'(ONE)) &&
      $signed(unit.normal_z) <= $signed(OUT_WIDTH'(ONE)) &&
      $signed(unit.normal_z) >= -$signed(OUT_WIDTH'(ONE)))
    else $error("normal component outside unit range");

endmodule
